// File: sv/tlb_pkg.sv
package tlb_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int PAGE_BITS_DEF  = 20;
	localparam int FRAME_BITS_DEF = 16;
	localparam int STAMP_BITS_DEF = 32;

	localparam int CMD_BITS  = 3;
	localparam int CAP_BITS  = 5;
	localparam int USED_BITS = 5;
	localparam int CNT_BITS  = 32;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOOKUP      = 3'd0,
		CMD_INSERT      = 3'd1,
		CMD_INVALIDATE  = 3'd2,
		CMD_CLEAR       = 3'd3,
		CMD_STATS_RESET = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACT,
		ST_SCAN,
		ST_EVICT
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_TOUCH,
		CELL_UPDATE,
		CELL_REMOVE_HIT,
		CELL_LOAD,
		CELL_EVICT_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     capture;
	} cell_ctl_t;

endpackage

// File: sv/tlb_req_if.sv
interface tlb_req_if #(
	parameter int PAGE_BITS  = tlb_pkg::PAGE_BITS_DEF,
	parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [tlb_pkg::CMD_BITS-1:0]  command;
	logic [PAGE_BITS-1:0]          page;
	logic [FRAME_BITS-1:0]         frame;

	modport source (output valid, output command, output page, output frame, input ready);
	modport sink (input valid, input command, input page, input frame, output ready);
endinterface

// File: sv/tlb_rsp_if.sv
interface tlb_rsp_if #(
	parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [FRAME_BITS-1:0]         found_frame;
	logic [tlb_pkg::CNT_BITS-1:0]  hit_count;
	logic [tlb_pkg::CNT_BITS-1:0]  miss_count;
	logic [tlb_pkg::USED_BITS-1:0] used_entries;

	modport source (output valid, output hit, output found_frame, output hit_count,
		output miss_count, output used_entries, input ready);
	modport sink (input valid, input hit, input found_frame, input hit_count,
		input miss_count, input used_entries, output ready);
endinterface

// File: sv/tlb_lru_translate_unit.sv
// Fully associative translation buffer with least-recently-used replacement, built as a
// row of ENTRIES cells, one entry per cell. A command word is taken when the unit is idle
// and its result word follows in the output register. Lookup, insert of a present page,
// insert into a table with room, invalidate, clear and statistics reset first compare the
// page in every cell and then act. An insert that must evict also scans the row first,
// because the smallest stamp travels one cell per clock along the row
// before the victim is known. The next word is taken while a result still waits; if that
// result has not been taken when the next one is ready, the unit holds until it is.
module tlb_lru_translate_unit #(
	parameter int ENTRIES    = tlb_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS  = tlb_pkg::PAGE_BITS_DEF,
	parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF,
	parameter int STAMP_BITS = tlb_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlb_pkg::CAP_BITS-1:0]  cfg_wdata,
	tlb_req_if.sink                       req,
	tlb_rsp_if.source                     rsp
);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);

	tlb_pkg::state_t                state_q, state_n;
	logic [tlb_pkg::CMD_BITS-1:0]   cmd_q;
	logic [PAGE_BITS-1:0]           page_q;
	logic [FRAME_BITS-1:0]          frame_q;
	logic [tlb_pkg::CAP_BITS-1:0]   cap_q;
	logic [CW-1:0]                  count_q, count_n;
	logic [STAMP_BITS-1:0]          use_q, use_n;
	logic [tlb_pkg::CNT_BITS-1:0]   hit_cnt_q, hit_cnt_n;
	logic [tlb_pkg::CNT_BITS-1:0]   miss_cnt_q, miss_cnt_n;
	logic [IW-1:0]                  scan_q;

	logic                           rsp_valid_q;
	logic                           rsp_hit_q;
	logic [FRAME_BITS-1:0]          rsp_frame_q;
	logic [tlb_pkg::CNT_BITS-1:0]   rsp_hit_cnt_q;
	logic [tlb_pkg::CNT_BITS-1:0]   rsp_miss_cnt_q;
	logic [tlb_pkg::USED_BITS-1:0]  rsp_used_q;

	tlb_pkg::cell_ctl_t             ctl;
	logic                           emit;
	logic                           out_free;
	logic                           accept;
	logic [CW-1:0]                  eff_cap;
	logic                           full;
	logic                           hit_any;
	logic                           is_lookup;
	logic                           needs_evict;
	logic [FRAME_BITS-1:0]          found;
	logic [STAMP_BITS-1:0]          new_stamp;
	logic [IW-1:0]                  load_idx;
	logic [IW-1:0]                  victim;

	logic [PAGE_BITS-1:0]           page_w   [ENTRIES];
	logic [FRAME_BITS-1:0]          frame_w  [ENTRIES];
	logic [STAMP_BITS-1:0]          stamp_w  [ENTRIES];
	logic [PAGE_BITS-1:0]           npage_w  [ENTRIES];
	logic [FRAME_BITS-1:0]          nframe_w [ENTRIES];
	logic [STAMP_BITS-1:0]          nstamp_w [ENTRIES];
	logic                           seen_w   [ENTRIES+1];
	logic                           first_w  [ENTRIES];
	logic                           mval_w   [ENTRIES+1];
	logic [STAMP_BITS-1:0]          mstamp_w [ENTRIES+1];
	logic [IW-1:0]                  midx_w   [ENTRIES+1];

	assign seen_w[0]   = 1'b0;
	assign mval_w[0]   = 1'b0;
	assign mstamp_w[0] = '0;
	assign midx_w[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i + 1 < ENTRIES) begin : g_next
			assign npage_w[i]  = page_w[i+1];
			assign nframe_w[i] = frame_w[i+1];
			assign nstamp_w[i] = stamp_w[i+1];
		end else begin : g_last
			assign npage_w[i]  = '0;
			assign nframe_w[i] = '0;
			assign nstamp_w[i] = '0;
		end

		tlb_cell #(
			.INDEX      (i),
			.ENTRIES    (ENTRIES),
			.PAGE_BITS  (PAGE_BITS),
			.FRAME_BITS (FRAME_BITS),
			.STAMP_BITS (STAMP_BITS)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.count        (count_q),
			.lookup_page  (req.page),
			.new_page     (page_q),
			.new_frame    (frame_q),
			.new_stamp    (new_stamp),
			.load_idx     (load_idx),
			.evict_idx    (victim),
			.next_page    (npage_w[i]),
			.next_frame   (nframe_w[i]),
			.next_stamp   (nstamp_w[i]),
			.page         (page_w[i]),
			.frame        (frame_w[i]),
			.stamp        (stamp_w[i]),
			.seen_in      (seen_w[i]),
			.seen_out     (seen_w[i+1]),
			.first        (first_w[i]),
			.min_valid_in (mval_w[i]),
			.min_stamp_in (mstamp_w[i]),
			.min_idx_in   (midx_w[i]),
			.min_valid    (mval_w[i+1]),
			.min_stamp    (mstamp_w[i+1]),
			.min_idx      (midx_w[i+1])
		);
	end

	assign hit_any = seen_w[ENTRIES];
	assign victim  = midx_w[ENTRIES];

	always_comb begin
		found = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			found = found | (first_w[i] ? frame_w[i] : '0);
		end
	end

	// A capacity of zero behaves as one, and anything above the row length as the full row.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign full        = count_q >= eff_cap;
	assign is_lookup   = cmd_q == tlb_pkg::CMD_LOOKUP;
	assign needs_evict = (cmd_q == tlb_pkg::CMD_INSERT) && !hit_any && full;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign accept      = req.valid && (state_q == tlb_pkg::ST_IDLE);
	assign new_stamp   = is_lookup ? use_q + 1'b1 : use_q;
	assign load_idx    = (state_q == tlb_pkg::ST_EVICT) ? IW'(count_q - 1'b1) : IW'(count_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tlb_pkg::ST_IDLE: begin
				if (accept) begin
					state_n = tlb_pkg::ST_ACT;
				end
			end
			tlb_pkg::ST_ACT: begin
				if (needs_evict) begin
					state_n = tlb_pkg::ST_SCAN;
				end else if (out_free) begin
					state_n = tlb_pkg::ST_IDLE;
				end
			end
			tlb_pkg::ST_SCAN: begin
				if (scan_q == IW'(ENTRIES - 1)) begin
					state_n = tlb_pkg::ST_EVICT;
				end
			end
			tlb_pkg::ST_EVICT: begin
				if (out_free) begin
					state_n = tlb_pkg::ST_IDLE;
				end
			end
			default: state_n = tlb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready   = 1'b0;
		ctl.capture = accept;
		ctl.op      = tlb_pkg::CELL_HOLD;
		emit        = 1'b0;
		unique case (state_q)
			tlb_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			tlb_pkg::ST_ACT: begin
				if (out_free && !needs_evict) begin
					emit = 1'b1;
					case (cmd_q)
						tlb_pkg::CMD_LOOKUP: begin
							ctl.op = hit_any ? tlb_pkg::CELL_TOUCH : tlb_pkg::CELL_HOLD;
						end
						tlb_pkg::CMD_INSERT: begin
							ctl.op = hit_any ? tlb_pkg::CELL_UPDATE : tlb_pkg::CELL_LOAD;
						end
						tlb_pkg::CMD_INVALIDATE: begin
							ctl.op = hit_any ? tlb_pkg::CELL_REMOVE_HIT : tlb_pkg::CELL_HOLD;
						end
						default: ctl.op = tlb_pkg::CELL_HOLD;
					endcase
				end
			end
			tlb_pkg::ST_EVICT: begin
				if (out_free) begin
					emit   = 1'b1;
					ctl.op = tlb_pkg::CELL_EVICT_LOAD;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_n    = count_q;
		use_n      = use_q;
		hit_cnt_n  = hit_cnt_q;
		miss_cnt_n = miss_cnt_q;
		case (cmd_q)
			tlb_pkg::CMD_LOOKUP: begin
				use_n = use_q + 1'b1;
				if (hit_any) begin
					hit_cnt_n = hit_cnt_q + 1'b1;
				end else begin
					miss_cnt_n = miss_cnt_q + 1'b1;
				end
			end
			tlb_pkg::CMD_INSERT: begin
				// An eviction frees one place and the append fills it again.
				if (state_q == tlb_pkg::ST_ACT && !hit_any) begin
					count_n = count_q + 1'b1;
				end
			end
			tlb_pkg::CMD_INVALIDATE: begin
				if (hit_any) begin
					count_n = count_q - 1'b1;
				end
			end
			tlb_pkg::CMD_CLEAR: begin
				count_n = '0;
			end
			tlb_pkg::CMD_STATS_RESET: begin
				use_n      = '0;
				hit_cnt_n  = '0;
				miss_cnt_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlb_pkg::ST_IDLE;
			cap_q       <= tlb_pkg::CAP_RESET;
			count_q     <= '0;
			use_q       <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == tlb_pkg::ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end else begin
				scan_q <= '0;
			end
			if (emit) begin
				count_q     <= count_n;
				use_q       <= use_n;
				hit_cnt_q   <= hit_cnt_n;
				miss_cnt_q  <= miss_cnt_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			page_q  <= req.page;
			frame_q <= req.frame;
		end
		if (emit) begin
			rsp_hit_q      <= is_lookup && hit_any;
			rsp_frame_q    <= (is_lookup && hit_any) ? found : '0;
			rsp_hit_cnt_q  <= hit_cnt_n;
			rsp_miss_cnt_q <= miss_cnt_n;
			rsp_used_q     <= tlb_pkg::USED_BITS'(count_n);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = rsp_hit_q;
	assign rsp.found_frame  = rsp_frame_q;
	assign rsp.hit_count    = rsp_hit_cnt_q;
	assign rsp.miss_count   = rsp_miss_cnt_q;
	assign rsp.used_entries = rsp_used_q;

`ifndef SYNTHESIS
	a_accept_to_act: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == tlb_pkg::ST_ACT)
		else $error("accepted word did not move the unit to its action cycle");

	a_evict_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlb_pkg::ST_SCAN || state_q == tlb_pkg::ST_EVICT) |->
			cmd_q == tlb_pkg::CMD_INSERT)
		else $error("eviction scan running for a command other than insert");

	a_victim_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlb_pkg::ST_EVICT |-> mval_w[ENTRIES] && CW'(victim) < count_q)
		else $error("eviction victim lies outside the filled part of the row");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= ENTRIES)
		else $error("entry count beyond the row length");
`endif
endmodule

// File: sv/tlb_cell.sv
module tlb_cell #(
	parameter int INDEX      = 0,
	parameter int ENTRIES    = tlb_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS  = tlb_pkg::PAGE_BITS_DEF,
	parameter int FRAME_BITS = tlb_pkg::FRAME_BITS_DEF,
	parameter int STAMP_BITS = tlb_pkg::STAMP_BITS_DEF
) (
	input  logic                               clk,
	input  tlb_pkg::cell_ctl_t                 ctl,
	input  logic [$clog2(ENTRIES+1)-1:0]       count,
	input  logic [PAGE_BITS-1:0]               lookup_page,
	input  logic [PAGE_BITS-1:0]               new_page,
	input  logic [FRAME_BITS-1:0]              new_frame,
	input  logic [STAMP_BITS-1:0]              new_stamp,
	input  logic [$clog2(ENTRIES)-1:0]         load_idx,
	input  logic [$clog2(ENTRIES)-1:0]         evict_idx,
	input  logic [PAGE_BITS-1:0]               next_page,
	input  logic [FRAME_BITS-1:0]              next_frame,
	input  logic [STAMP_BITS-1:0]              next_stamp,
	output logic [PAGE_BITS-1:0]               page,
	output logic [FRAME_BITS-1:0]              frame,
	output logic [STAMP_BITS-1:0]              stamp,
	input  logic                               seen_in,
	output logic                               seen_out,
	output logic                               first,
	input  logic                               min_valid_in,
	input  logic [STAMP_BITS-1:0]              min_stamp_in,
	input  logic [$clog2(ENTRIES)-1:0]         min_idx_in,
	output logic                               min_valid,
	output logic [STAMP_BITS-1:0]              min_stamp,
	output logic [$clog2(ENTRIES)-1:0]         min_idx
);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int IW = $clog2(ENTRIES);

	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  match_q;
	logic                  min_valid_q;
	logic [STAMP_BITS-1:0] min_stamp_q;
	logic [IW-1:0]         min_idx_q;

	logic live;
	logic has_next;
	logic hit_here;
	logic is_load;
	logic from_evict;
	logic take_min;

	assign live       = count > CW'(INDEX);
	assign has_next   = int'(count) > INDEX + 1;
	assign hit_here   = match_q & live;
	assign seen_out   = seen_in | hit_here;
	assign first      = hit_here & ~seen_in;
	assign is_load    = load_idx == IW'(INDEX);
	assign from_evict = IW'(INDEX) >= evict_idx;
	// Strictly smaller only, so the earliest entry keeps a tie.
	assign take_min   = live & (~min_valid_in | (stamp_q < min_stamp_in));

	assign page  = page_q;
	assign frame = frame_q;
	assign stamp = stamp_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_q <= page_q == lookup_page;
		end
		unique case (ctl.op)
			tlb_pkg::CELL_TOUCH: begin
				if (first) begin
					stamp_q <= new_stamp;
				end
			end
			tlb_pkg::CELL_UPDATE: begin
				if (first) begin
					frame_q <= new_frame;
					stamp_q <= new_stamp;
				end
			end
			tlb_pkg::CELL_REMOVE_HIT: begin
				if (seen_out && has_next) begin
					page_q  <= next_page;
					frame_q <= next_frame;
					stamp_q <= next_stamp;
				end
			end
			tlb_pkg::CELL_LOAD: begin
				if (is_load) begin
					page_q  <= new_page;
					frame_q <= new_frame;
					stamp_q <= new_stamp;
				end
			end
			tlb_pkg::CELL_EVICT_LOAD: begin
				if (is_load) begin
					page_q  <= new_page;
					frame_q <= new_frame;
					stamp_q <= new_stamp;
				end else if (from_evict && has_next) begin
					page_q  <= next_page;
					frame_q <= next_frame;
					stamp_q <= next_stamp;
				end
			end
			default: begin
			end
		endcase
	end

	// The running minimum moves one cell along the row on every clock.
	always_ff @(posedge clk) begin
		if (take_min) begin
			min_valid_q <= 1'b1;
			min_stamp_q <= stamp_q;
			min_idx_q   <= IW'(INDEX);
		end else begin
			min_valid_q <= min_valid_in;
			min_stamp_q <= min_stamp_in;
			min_idx_q   <= min_idx_in;
		end
	end

	assign min_valid = min_valid_q;
	assign min_stamp = min_stamp_q;
	assign min_idx   = min_idx_q;
endmodule

// File: verif/tlb_lru_translate_unit_tb.sv
module tlb_lru_translate_unit_tb;

	localparam int ENTRIES = tlb_pkg::ENTRIES_DEF;
	localparam int PB      = tlb_pkg::PAGE_BITS_DEF;
	localparam int FB      = tlb_pkg::FRAME_BITS_DEF;

	// Command codes that the block must ignore.
	localparam logic [tlb_pkg::CMD_BITS-1:0] CMD_SPARE5 = 3'd5;
	localparam logic [tlb_pkg::CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [tlb_pkg::CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

	typedef struct packed {
		logic                          hit;
		logic [FB-1:0]                 found_frame;
		logic [tlb_pkg::CNT_BITS-1:0]  hit_count;
		logic [tlb_pkg::CNT_BITS-1:0]  miss_count;
		logic [tlb_pkg::USED_BITS-1:0] used_entries;
	} tlb_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [tlb_pkg::CAP_BITS-1:0] cfg_wdata;

	tlb_req_if req_bus ();
	tlb_rsp_if rsp_bus ();

	tlb_lru_translate_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// Shadow copy of the translation table.
	logic [PB-1:0]                tbl_page  [ENTRIES];
	logic [FB-1:0]                tbl_frame [ENTRIES];
	logic [31:0]                  tbl_stamp [ENTRIES];
	int                           tbl_fill;
	logic [31:0]                  use_ctr;
	logic [tlb_pkg::CNT_BITS-1:0] hit_ctr;
	logic [tlb_pkg::CNT_BITS-1:0] miss_ctr;
	logic [tlb_pkg::CAP_BITS-1:0] cap_reg;

	tlb_result_t tlb_expected [$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        rsp_hold;
	logic [PB-1:0] page_pool [24];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void drop_slot(int idx);
		int i;
		for (i = idx; i + 1 < tbl_fill; i++) begin
			tbl_page[i]  = tbl_page[i + 1];
			tbl_frame[i] = tbl_frame[i + 1];
			tbl_stamp[i] = tbl_stamp[i + 1];
		end
		tbl_fill--;
	endfunction

	function automatic tlb_result_t translate_word(logic [tlb_pkg::CMD_BITS-1:0] c,
		logic [PB-1:0] p, logic [FB-1:0] f);
		tlb_result_t r;
		int slot, victim, lim, i;
		r = '0;
		slot = -1;
		for (i = 0; i < tbl_fill; i++)
			if (slot < 0 && tbl_page[i] == p)
				slot = i;
		case (c)
			tlb_pkg::CMD_LOOKUP: begin
				use_ctr++;
				if (slot >= 0) begin
					tbl_stamp[slot] = use_ctr;
					hit_ctr++;
					r.hit = 1'b1;
					r.found_frame = tbl_frame[slot];
				end else begin
					miss_ctr++;
				end
			end
			tlb_pkg::CMD_INSERT: begin
				if (slot >= 0) begin
					tbl_frame[slot] = f;
					tbl_stamp[slot] = use_ctr;
				end else begin
					lim = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
					// The victim is the oldest stamp; the earliest slot wins a tie.
					if (tbl_fill >= lim && tbl_fill > 0) begin
						victim = 0;
						for (i = 1; i < tbl_fill; i++)
							if (tbl_stamp[i] < tbl_stamp[victim])
								victim = i;
						drop_slot(victim);
					end
					if (tbl_fill < ENTRIES) begin
						tbl_page[tbl_fill]  = p;
						tbl_frame[tbl_fill] = f;
						tbl_stamp[tbl_fill] = use_ctr;
						tbl_fill++;
					end
				end
			end
			tlb_pkg::CMD_INVALIDATE: begin
				if (slot >= 0)
					drop_slot(slot);
			end
			tlb_pkg::CMD_CLEAR: begin
				tbl_fill = 0;
			end
			tlb_pkg::CMD_STATS_RESET: begin
				hit_ctr = '0;
				miss_ctr = '0;
				use_ctr = '0;
			end
			default: ;
		endcase
		r.hit_count = hit_ctr;
		r.miss_count = miss_ctr;
		r.used_entries = tlb_pkg::USED_BITS'(tbl_fill);
		return r;
	endfunction

	task automatic note_mismatch(string what, tlb_result_t want, tlb_result_t got);
		if (mismatches < 10) begin
			$display("ERROR %s: expected hit=%0d frame=%h hits=%0d misses=%0d used=%0d,",
				what, want.hit, want.found_frame, want.hit_count, want.miss_count,
				want.used_entries);
			$display("      got hit=%0d frame=%h hits=%0d misses=%0d used=%0d",
				got.hit, got.found_frame, got.hit_count, got.miss_count, got.used_entries);
		end
		mismatches++;
	endtask

	// Result side: checks each word taken and drives ready.
	always @(posedge clk) begin : rsp_side
		tlb_result_t got, want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got.hit = rsp_bus.hit;
			got.found_frame = rsp_bus.found_frame;
			got.hit_count = rsp_bus.hit_count;
			got.miss_count = rsp_bus.miss_count;
			got.used_entries = rsp_bus.used_entries;
			if (tlb_expected.size() == 0) begin
				note_mismatch("unexpected result word", '0, got);
			end else begin
				want = tlb_expected.pop_front();
				if (got !== want)
					note_mismatch("result word", want, got);
			end
		end
		rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(logic [tlb_pkg::CMD_BITS-1:0] c, logic [PB-1:0] p,
		logic [FB-1:0] f);
		int gap;
		tlb_result_t want;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= c;
		req_bus.page <= p;
		req_bus.frame <= f;
		do @(posedge clk); while (!req_bus.ready);
		want = translate_word(c, p, f);
		tlb_expected = {tlb_expected, want};
	endtask

	// Waits for every outstanding result, then lets the unit settle.
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		while (tlb_expected.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	task automatic set_capacity(logic [tlb_pkg::CAP_BITS-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	task automatic send_random_word();
		int pick;
		logic [PB-1:0] p;
		logic [tlb_pkg::CMD_BITS-1:0] c;
		pick = $urandom_range(99);
		p = ($urandom_range(9) == 0) ? PB'($urandom) : page_pool[$urandom_range(23)];
		if (pick < 42)
			c = tlb_pkg::CMD_LOOKUP;
		else if (pick < 74)
			c = tlb_pkg::CMD_INSERT;
		else if (pick < 86)
			c = tlb_pkg::CMD_INVALIDATE;
		else if (pick < 88)
			c = tlb_pkg::CMD_CLEAR;
		else if (pick < 90)
			c = tlb_pkg::CMD_STATS_RESET;
		else if (pick < 93)
			c = CMD_SPARE5 + tlb_pkg::CMD_BITS'($urandom_range(2));
		else begin
			c = tlb_pkg::CMD_LOOKUP;
			p = PB'($urandom);
		end
		send_word(c, p, FB'($urandom));
	endtask

	task automatic run_round(logic [tlb_pkg::CAP_BITS-1:0] cap, int count);
		int i;
		set_capacity(cap);
		for (i = 0; i < 24; i++)
			page_pool[i] = PB'($urandom);
		for (i = 0; i < count; i++)
			send_random_word();
	endtask

	task automatic test_basic_commands();
		send_word(tlb_pkg::CMD_LOOKUP, '0, '0);
		send_word(tlb_pkg::CMD_INSERT, '1, '1);
		send_word(tlb_pkg::CMD_INSERT, '0, '0);
		send_word(tlb_pkg::CMD_LOOKUP, '1, '0);
		send_word(tlb_pkg::CMD_LOOKUP, '0, '1);
		// An insert of a page already present rewrites it where it stands.
		send_word(tlb_pkg::CMD_INSERT, '0, 16'h5a5a);
		send_word(tlb_pkg::CMD_LOOKUP, '0, '0);
		send_word(tlb_pkg::CMD_INVALIDATE, 20'h12345, '0);
		send_word(tlb_pkg::CMD_INVALIDATE, '1, '0);
		send_word(CMD_SPARE5, '1, '1);
		send_word(CMD_SPARE6, 20'h0f0f0, 16'ha5a5);
		send_word(CMD_SPARE7, '0, '0);
		send_word(tlb_pkg::CMD_STATS_RESET, '0, '0);
		send_word(tlb_pkg::CMD_CLEAR, '0, '0);
	endtask

	task automatic test_eviction();
		set_capacity(5'd2);
		// Inserts do not advance the use counter, so these two stamps tie.
		send_word(tlb_pkg::CMD_INSERT, 20'h00100, 16'h0001);
		send_word(tlb_pkg::CMD_INSERT, 20'h00200, 16'h0002);
		send_word(tlb_pkg::CMD_INSERT, 20'h00300, 16'h0003);
		send_word(tlb_pkg::CMD_LOOKUP, 20'h00200, '0);
		send_word(tlb_pkg::CMD_INSERT, 20'h00400, 16'h0004);
		send_word(tlb_pkg::CMD_LOOKUP, 20'h00300, '0);
	endtask

	task automatic test_capacity_limits();
		// Zero acts as one; the fill stays at two because only one entry goes.
		set_capacity(5'd0);
		send_word(tlb_pkg::CMD_INSERT, 20'h00500, 16'h0005);
		send_word(tlb_pkg::CMD_LOOKUP, 20'h00400, '0);
		set_capacity(5'd31);
		send_word(tlb_pkg::CMD_INSERT, 20'h00600, 16'h0006);
		send_word(tlb_pkg::CMD_INSERT, 20'h00700, 16'h0007);
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_round(5'd16, 175);
		run_round(5'd1, 175);
		send_idle_pct = 77;
		run_round(5'd0, 175);
		run_round(5'd31, 175);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		run_round(5'd4, 175);
		run_round(tlb_pkg::CAP_BITS'($urandom), 175);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		run_round(5'd8, 175);
		run_round(tlb_pkg::CAP_BITS'($urandom_range(1, ENTRIES)), 175);
	endtask

	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_capacity(5'd3);
		for (i = 0; i < 24; i++)
			page_pool[i] = PB'($urandom);
		// The receiver refuses every word for a long stretch while words keep coming.
		fork
			begin
				rsp_hold <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		join_none
		for (i = 0; i < 100; i++)
			send_random_word();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_bus.valid = 1'b0;
		req_bus.command = '0;
		req_bus.page = '0;
		req_bus.frame = '0;
		rsp_bus.ready = 1'b0;
		rsp_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		tbl_fill = 0;
		use_ctr = '0;
		hit_ctr = '0;
		miss_ctr = '0;
		cap_reg = tlb_pkg::CAP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_basic_commands();
		test_eviction();
		test_capacity_limits();
		test_random_traffic();
		test_backpressure();
		set_capacity(tlb_pkg::CAP_RESET);
		send_word(tlb_pkg::CMD_LOOKUP, page_pool[0], '0);
		drain_results();

		if (mismatches == 0 && tlb_expected.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
